>>> rtl/query_token_lexer_unit_defines.svh
// assertion macros used by the query token lexer queue
`ifndef QUERY_TOKEN_LEXER_UNIT_DEFINES_SVH
`define QUERY_TOKEN_LEXER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define QTL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define QTL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/qtl_pkg.sv
// shared types and token codes of the query token lexer
package qtl_pkg;

	// token kinds
	localparam logic [4:0] K_END     = 5'd0;
	localparam logic [4:0] K_HYPHEN  = 5'd1;
	localparam logic [4:0] K_OPEN    = 5'd2;
	localparam logic [4:0] K_CLOSE   = 5'd3;
	localparam logic [4:0] K_EQ      = 5'd4;
	localparam logic [4:0] K_COLON   = 5'd5;
	localparam logic [4:0] K_COMMA   = 5'd6;
	localparam logic [4:0] K_EQEQ    = 5'd7;
	localparam logic [4:0] K_NE      = 5'd8;
	localparam logic [4:0] K_SFEQ    = 5'd9;
	localparam logic [4:0] K_SFNE    = 5'd10;
	localparam logic [4:0] K_STRING  = 5'd11;
	localparam logic [4:0] K_NUMBER  = 5'd12;
	localparam logic [4:0] K_INVALID = 5'd13;
	localparam logic [4:0] K_LEADER  = 5'd14;
	localparam logic [4:0] K_STAR    = 5'd19;
	localparam logic [4:0] K_SBYTE   = 5'd20;

	// one input item
	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_end;
	} in_t;

	// one result item
	typedef struct packed {
		logic [4:0]  token_kind;
		logic [31:0] number_value;
		logic [7:0]  string_byte;
		logic        last_of_run;
	} out_t;

	// queue entry: the one or two results of one input item
	typedef struct packed {
		out_t r0;
		out_t r1;
		logic two;
	} entry_t;

endpackage

>>> rtl/qtl_front.sv
// front end: accepts text bytes, runs the scanner state and forms result pairs
module qtl_front #(
	parameter int NUMBER_BITS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  qtl_pkg::in_t    in_data,
	input  logic            q_full,
	output logic            push,
	output qtl_pkg::entry_t push_entry
);

	// scan phases
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_OP     = 3'd1;
	localparam logic [2:0] PH_NUMBER = 3'd2;
	localparam logic [2:0] PH_WORD   = 3'd3;
	localparam logic [2:0] PH_STRING = 3'd4;
	localparam logic [2:0] PH_ESCAPE = 3'd5;

	// pending operator prefixes held in the word position
	localparam logic [3:0] OP_EQ     = 4'd1;
	localparam logic [3:0] OP_EQEQ   = 4'd2;
	localparam logic [3:0] OP_BANG   = 4'd3;
	localparam logic [3:0] OP_BANGEQ = 4'd4;
	localparam logic [3:0] POS_MAX   = 4'd15;

	// characters
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_EQUAL = 8'h3D;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CH_OPEN  = 8'h5B;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_CLOSE = 8'h5D;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;

	// keyword table, text right-justified
	localparam int         KW_COUNT = 5;
	localparam logic [79:0] KW_TEXT [KW_COUNT] =
		'{"leader", "if", "extract", "exists", {"is_", "missing"}};
	localparam logic [3:0]  KW_LEN [KW_COUNT] = '{4'd6, 4'd2, 4'd7, 4'd6, 4'd10};

	typedef struct packed {
		logic [2:0]             phase;
		logic [NUMBER_BITS-1:0] acc;
		logic                   ovf;
		logic [KW_COUNT-1:0]    cand;
		logic [3:0]             pos;
	} scan_t;

	typedef struct packed {
		scan_t      st;
		logic       emit;
		logic [4:0] kind;
	} idle_t;

	localparam scan_t SCAN_RESET = '{PH_IDLE, '0, 1'b0, '1, 4'd0};

	scan_t st_q;

	// drop keywords that do not match the character at this position
	function automatic logic [KW_COUNT-1:0] kw_step(input logic [KW_COUNT-1:0] cand,
			input logic [3:0] pos, input logic [7:0] c);
		logic [KW_COUNT-1:0] r;
		r = cand;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (!(pos < KW_LEN[k] &&
					KW_TEXT[k][8*(int'(KW_LEN[k]) - 1 - int'(pos)) +: 8] == c)) begin
				r[k] = 1'b0;
			end
		end
		return r;
	endfunction

	// first keyword still alive whose length is the word length
	function automatic logic [4:0] kw_kind(input logic [KW_COUNT-1:0] cand,
			input logic [3:0] pos);
		logic [4:0] kind;
		kind = qtl_pkg::K_INVALID;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			if (cand[k] && KW_LEN[k] == pos) begin
				kind = qtl_pkg::K_LEADER + 5'(k);
			end
		end
		return kind;
	endfunction

	// decimal digit into the accumulator, sticky overflow
	function automatic scan_t num_step(input scan_t s, input logic [7:0] c);
		scan_t r;
		logic [NUMBER_BITS+3:0] wide;
		r = s;
		wide = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1) + {{NUMBER_BITS{1'b0}}, c[3:0]};
		if (!s.ovf) begin
			if (|wide[NUMBER_BITS+3:NUMBER_BITS]) begin
				r.ovf = 1'b1;
			end else begin
				r.acc = wide[NUMBER_BITS-1:0];
			end
		end
		return r;
	endfunction

	// letter into the keyword matcher
	function automatic scan_t word_step(input scan_t s, input logic [7:0] c);
		scan_t r;
		r = s;
		r.cand = kw_step(s.cand, s.pos, c);
		if (s.pos != POS_MAX) begin
			r.pos = s.pos + 4'd1;
		end
		return r;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[CH_0:CH_9]};
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return c inside {[CH_LC_A:CH_LC_Z], [CH_UC_A:CH_UC_Z], CH_UNDER};
	endfunction

	// a byte handled from the idle phase
	function automatic idle_t idle_scan(input logic [7:0] c);
		idle_t r;
		r.st   = SCAN_RESET;
		r.emit = 1'b0;
		r.kind = qtl_pkg::K_INVALID;
		case (c)
			CH_SPACE, CH_TAB: begin
				r.emit = 1'b0;
			end
			CH_MINUS: begin r.emit = 1'b1; r.kind = qtl_pkg::K_HYPHEN; end
			CH_OPEN:  begin r.emit = 1'b1; r.kind = qtl_pkg::K_OPEN;   end
			CH_CLOSE: begin r.emit = 1'b1; r.kind = qtl_pkg::K_CLOSE;  end
			CH_STAR:  begin r.emit = 1'b1; r.kind = qtl_pkg::K_STAR;   end
			CH_COLON: begin r.emit = 1'b1; r.kind = qtl_pkg::K_COLON;  end
			CH_COMMA: begin r.emit = 1'b1; r.kind = qtl_pkg::K_COMMA;  end
			CH_EQUAL: begin r.st.phase = PH_OP; r.st.pos = OP_EQ;   end
			CH_BANG:  begin r.st.phase = PH_OP; r.st.pos = OP_BANG; end
			CH_QUOTE: begin r.st.phase = PH_STRING; end
			default: begin
				if (is_digit(c)) begin
					r.st.phase = PH_NUMBER;
					r.st.acc   = {{(NUMBER_BITS-4){1'b0}}, c[3:0]};
				end else if (is_letter(c)) begin
					r.st.phase = PH_WORD;
					r.st       = word_step(r.st, c);
				end else begin
					r.emit = 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	function automatic qtl_pkg::out_t make_res(input logic [4:0] kind,
			input logic [31:0] num, input logic [7:0] sb);
		qtl_pkg::out_t r;
		r.token_kind   = kind;
		r.number_value = num;
		r.string_byte  = sb;
		r.last_of_run  = 1'b0;
		return r;
	endfunction

	// pending number as a result
	function automatic qtl_pkg::out_t number_res(input scan_t s);
		logic [63:0] ext;
		ext = 64'(s.acc);
		if (s.ovf) begin
			return make_res(qtl_pkg::K_INVALID, 32'd0, 8'd0);
		end
		return make_res(qtl_pkg::K_NUMBER, ext[31:0], 8'd0);
	endfunction

	// pending operator prefix as a result
	function automatic logic [4:0] op_kind(input logic [3:0] pos);
		logic [4:0] k;
		case (pos)
			OP_EQ:   k = qtl_pkg::K_EQ;
			OP_EQEQ: k = qtl_pkg::K_EQEQ;
			OP_BANG: k = qtl_pkg::K_INVALID;
			default: k = qtl_pkg::K_NE;
		endcase
		return k;
	endfunction

	logic          accept;
	logic [7:0]    c;
	logic          op_live;
	idle_t         id;
	scan_t         nxt;
	logic          pre_v;
	logic          post_v;
	logic          do_idle;
	qtl_pkg::out_t pre;
	qtl_pkg::out_t post;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign c        = in_data.in_byte;
	assign op_live  = (st_q.pos >= OP_EQ) && (st_q.pos <= OP_BANGEQ);
	assign id       = idle_scan(c);

	// scanner step: an optional flushed token, then an optional idle token
	always_comb begin
		nxt     = st_q;
		pre_v   = 1'b0;
		post_v  = 1'b0;
		do_idle = 1'b0;
		pre     = make_res(qtl_pkg::K_END, 32'd0, 8'd0);
		post    = make_res(qtl_pkg::K_END, 32'd0, 8'd0);
		if (in_data.stream_end) begin
			case (st_q.phase)
				PH_OP: begin
					pre_v = op_live;
					pre   = make_res(op_kind(st_q.pos), 32'd0, 8'd0);
				end
				PH_NUMBER: begin
					pre_v = 1'b1;
					pre   = number_res(st_q);
				end
				PH_WORD: begin
					pre_v = 1'b1;
					pre   = make_res(kw_kind(st_q.cand, st_q.pos), 32'd0, 8'd0);
				end
				PH_STRING, PH_ESCAPE: begin
					pre_v = 1'b1;
					pre   = make_res(qtl_pkg::K_INVALID, 32'd0, 8'd0);
				end
				default: begin
					pre_v = 1'b0;
				end
			endcase
			post_v = 1'b1;
			nxt    = SCAN_RESET;
		end else begin
			case (st_q.phase)
				PH_OP: begin
					if (!op_live) begin
						do_idle = 1'b1;
					end else if (c == CH_EQUAL && (st_q.pos == OP_EQ || st_q.pos == OP_BANG)) begin
						nxt.pos = st_q.pos + 4'd1;
					end else if (c == CH_EQUAL) begin
						pre_v = 1'b1;
						pre   = make_res((st_q.pos == OP_EQEQ) ? qtl_pkg::K_SFEQ : qtl_pkg::K_SFNE,
							32'd0, 8'd0);
						nxt   = SCAN_RESET;
					end else begin
						pre_v   = 1'b1;
						pre     = make_res(op_kind(st_q.pos), 32'd0, 8'd0);
						do_idle = 1'b1;
					end
				end
				PH_NUMBER: begin
					if (is_digit(c)) begin
						nxt = num_step(st_q, c);
					end else begin
						pre_v   = 1'b1;
						pre     = number_res(st_q);
						do_idle = 1'b1;
					end
				end
				PH_WORD: begin
					if (is_letter(c)) begin
						nxt = word_step(st_q, c);
					end else begin
						pre_v   = 1'b1;
						pre     = make_res(kw_kind(st_q.cand, st_q.pos), 32'd0, 8'd0);
						do_idle = 1'b1;
					end
				end
				PH_STRING: begin
					if (c == CH_QUOTE) begin
						pre_v = 1'b1;
						pre   = make_res(qtl_pkg::K_STRING, 32'd0, 8'd0);
						nxt   = SCAN_RESET;
					end else if (c == CH_BSL) begin
						nxt.phase = PH_ESCAPE;
					end else begin
						pre_v = 1'b1;
						pre   = make_res(qtl_pkg::K_SBYTE, 32'd0, c);
					end
				end
				PH_ESCAPE: begin
					if (c == CH_BSL || c == CH_QUOTE) begin
						pre_v     = 1'b1;
						pre       = make_res(qtl_pkg::K_SBYTE, 32'd0, c);
						nxt.phase = PH_STRING;
					end else begin
						pre_v   = 1'b1;
						pre     = make_res(qtl_pkg::K_INVALID, 32'd0, 8'd0);
						do_idle = 1'b1;
					end
				end
				default: begin
					do_idle = 1'b1;
				end
			endcase
			if (do_idle) begin
				nxt    = id.st;
				post_v = id.emit;
				post   = make_res(id.kind, 32'd0, 8'd0);
			end
		end
	end

	// pack the results of this item into one queue entry
	always_comb begin
		push_entry.two            = pre_v && post_v;
		push_entry.r0             = pre_v ? pre : post;
		push_entry.r0.last_of_run = !(pre_v && post_v);
		push_entry.r1             = post;
		push_entry.r1.last_of_run = 1'b1;
	end

	assign push = accept && (pre_v || post_v);

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= SCAN_RESET;
		end else if (accept) begin
			st_q <= nxt;
		end
	end

endmodule

>>> rtl/qtl_queue.sv
// two-entry queue between the scanner front end and the result back end
module qtl_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  qtl_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output qtl_pkg::entry_t head
);

	`include "query_token_lexer_unit_defines.svh"

	localparam int DEPTH = 2;

	qtl_pkg::entry_t mem_q [DEPTH];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign full       = (count_q == 2'(DEPTH));
	assign head_valid = (count_q != 2'd0);
	assign head       = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	`QTL_ASSERT_NOW(a_no_push_full, push, count_q != 2'(DEPTH), "push into a full queue")
	`QTL_ASSERT_NOW(a_no_pop_empty, pop, count_q != 2'd0, "pop from an empty queue")
	`QTL_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 2'd1, "fill count off")

endmodule

>>> rtl/qtl_back.sv
// back end: splits queue entries into single results behind an output register
module qtl_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  qtl_pkg::entry_t head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output qtl_pkg::out_t   out_data
);

	logic          out_valid_q;
	qtl_pkg::out_t out_q;
	logic          sel_q;
	logic          load;

	assign load      = !out_valid_q || out_ready;
	assign pop       = load && head_valid && (sel_q || !head.two);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// output register payload
	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			out_q <= sel_q ? head.r1 : head.r0;
		end
	end

	// output valid and second-result select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sel_q       <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				sel_q <= !sel_q && head.two;
			end
		end
	end

endmodule

>>> rtl/query_token_lexer_unit.sv
// top level of the query token lexer: scanner, entry queue and result stage
//
//  channel | signals                        | item
//  --------+--------------------------------+-------------------------------------
//  in      | in_valid, in_ready, in_data    | one text byte or end-of-input mark
//  out     | out_valid, out_ready, out_data | one token or one unescaped string byte
//
// one input item is taken per cycle while the queue is not full; its one or two results
// are formed in the same cycle and queued as one entry, and the result stage sends one
// result per cycle while out_ready allows, the second of a pair after the first.
// a byte that gives no result (blank, part of a token) only updates the scanner.
// the two-entry queue lets input keep flowing while out_ready is low, until full.
// reset clears scanner state, queue count and output valid; no clearing pass.
module query_token_lexer_unit #(
	parameter int NUMBER_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  qtl_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output qtl_pkg::out_t out_data
);

	logic            q_full;
	logic            push;
	qtl_pkg::entry_t push_entry;
	logic            pop;
	logic            head_valid;
	qtl_pkg::entry_t head;

	// byte scanner
	qtl_front #(
		.NUMBER_BITS(NUMBER_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.q_full    (q_full),
		.push      (push),
		.push_entry(push_entry)
	);

	// decoupling queue
	qtl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	// result stage
	qtl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
